// ----- sv/srt_pkg.sv -----
// types, codes and defaults shared by the sorted record table
`default_nettype none

package srt_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int KEY_W            = 32;
   localparam int LIKES_W          = 31;
   localparam int PAYLOAD_W        = 16;
   localparam int COUNT_W          = 7;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_LOOKUP = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      kind_type                    kind;
      logic signed [KEY_W-1:0]     key;
      logic [LIKES_W-1:0]          new_likes;
      logic [PAYLOAD_W-1:0]        new_payload;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic [LIKES_W-1:0]          hit_likes;
      logic [PAYLOAD_W-1:0]        hit_payload;
      logic [COUNT_W-1:0]          entry_count;
      logic                        top_valid;
      logic signed [KEY_W-1:0]     top_key;
      logic [LIKES_W-1:0]          top_likes;
      logic [PAYLOAD_W-1:0]        top_payload;
   } rsp_type;

   // one slot of the table
   typedef struct packed {
      logic                        valid;
      logic signed [KEY_W-1:0]     key;
      logic [LIKES_W-1:0]          likes;
      logic [PAYLOAD_W-1:0]        payload;
   } rec_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                        ins;
      logic                        del;
      logic                        kind_del;
      logic signed [KEY_W-1:0]     key;
      logic [LIKES_W-1:0]          likes;
      logic [PAYLOAD_W-1:0]        payload;
   } cell_ctrl_type;

   // running search / max result handed from cell to cell
   typedef struct packed {
      logic                        found;
      logic [LIKES_W-1:0]          hit_likes;
      logic [PAYLOAD_W-1:0]        hit_payload;
      logic                        best_valid;
      logic signed [KEY_W-1:0]     best_key;
      logic [LIKES_W-1:0]          best_likes;
      logic [PAYLOAD_W-1:0]        best_payload;
   } wave_type;

endpackage

`default_nettype wire

// ----- sv/sorted_record_table.sv -----
// sorted record table: a chain of record cells in ascending key order
//
// requests come in on req_valid / req_stall / req_data: insert a record,
// delete the first record with a key, or look that record up. one response
// per request goes out on rsp_valid / rsp_stall / rsp_data with the status,
// the hit record, the record count and the most-liked record.
// one request is in work at a time. an insert shifts the chain in the apply
// state; after that a scan wave walks down the chain one cell per cycle and
// collects the first key match and the most-liked record. the response is
// registered once the wave has left the last cell, and a new request is
// taken only after the response is written. the scan wave through the cell
// chain sets how long a request takes. a delete shifts the chain left in the
// cycle the response is written.
// reset empties the table (all cells marked invalid) and drops any
// pending response. while the response register is held by rsp_stall the
// next request is still taken and run; it only waits to be written out.
`default_nettype none

module sorted_record_table import srt_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int TOTAL_W = $clog2(CAPACITY + 1);
   localparam int CNT_W   = $clog2(CAPACITY);

   // one-hot sequencer
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_APPLY  = 4'b0010,
      ST_WAVE   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   req_type              op_ff, op_in;
   status_type           status_ff, status_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 accept;
   logic                 full;
   logic                 finish_go;
   logic                 is_search;
   logic                 do_insert;
   logic                 do_delete;
   wave_type             result;
   status_type           final_status;
   cell_ctrl_type        ctrl;

   rec_type              recs       [CAPACITY];
   rec_type              left_recs  [CAPACITY];
   rec_type              right_recs [CAPACITY];
   logic                 flags      [CAPACITY];
   logic                 left_flags [CAPACITY];
   wave_type             carries    [CAPACITY+1];

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = (total_ff == TOTAL_W'(CAPACITY));
   assign is_search = (op_ff.kind == KIND_DELETE) || (op_ff.kind == KIND_LOOKUP);
   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign result    = carries[CAPACITY];

   // insert happens in the apply cycle, delete when the response is written
   assign do_insert = (state_ff == ST_APPLY) && (op_ff.kind == KIND_INSERT) && !full;
   assign do_delete = finish_go && (op_ff.kind == KIND_DELETE) && result.found;

   always_comb begin
      ctrl.ins      = do_insert;
      ctrl.del      = do_delete;
      ctrl.kind_del = (op_ff.kind == KIND_DELETE);
      ctrl.key      = op_ff.key;
      ctrl.likes    = op_ff.new_likes;
      ctrl.payload  = op_ff.new_payload;
   end

   // cell chain, head at index zero
   assign carries[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_recs[i]  = '0;
         assign left_flags[i] = 1'b0;
      end else begin : g_body
         assign left_recs[i]  = recs[i-1];
         assign left_flags[i] = flags[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_recs[i] = '0;
      end else begin : g_mid
         assign right_recs[i] = recs[i+1];
      end

      srt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .head       ((i == 0) ? 1'b1 : 1'b0),
         .ctrl       (ctrl),
         .left_rec   (left_recs[i]),
         .left_flag  (left_flags[i]),
         .right_rec  (right_recs[i]),
         .rec        (recs[i]),
         .flag       (flags[i]),
         .prev_carry (carries[i]),
         .next_carry (carries[i+1])
      );
   end

   always_comb begin
      final_status = status_ff;
      if ((status_ff == STATUS_OK) && is_search && !result.found) begin
         final_status = STATUS_NOT_FOUND;
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      status_in = status_ff;
      total_in  = total_ff;
      cnt_in    = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_data;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            status_in = STATUS_OK;
            if (op_ff.kind == KIND_INSERT) begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  total_in = total_ff + TOTAL_W'(1);
               end
            end else if (is_search && (total_ff == '0)) begin
               status_in = STATUS_EMPTY;
            end
            // the wave walks one cell per cycle once the chain has settled
            cnt_in   = CNT_W'(CAPACITY - 1);
            state_in = ST_WAVE;
         end
         ST_WAVE: begin
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               if (do_delete) begin
                  total_in = total_ff - TOTAL_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish_go) begin
         rsp_valid_in        = 1'b1;
         rsp_in.status       = final_status;
         rsp_in.hit_likes    = '0;
         rsp_in.hit_payload  = '0;
         if ((final_status == STATUS_OK) && is_search) begin
            rsp_in.hit_likes   = result.hit_likes;
            rsp_in.hit_payload = result.hit_payload;
         end
         rsp_in.entry_count  = COUNT_W'(total_in);
         rsp_in.top_valid    = result.best_valid;
         rsp_in.top_key      = result.best_valid ? result.best_key : '0;
         rsp_in.top_likes    = result.best_valid ? result.best_likes : '0;
         rsp_in.top_payload  = result.best_valid ? result.best_payload : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      status_ff <= status_in;
      cnt_ff    <= cnt_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- sv/srt_cell.sv -----
// one table slot: holds a record, shifts with its neighbors, forwards the scan
`default_nettype none

module srt_cell import srt_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          head,
   input  wire cell_ctrl_type ctrl,
   input  wire rec_type       left_rec,
   input  wire logic          left_flag,
   input  wire rec_type       right_rec,
   output rec_type            rec,
   output logic               flag,
   input  wire wave_type      prev_carry,
   output wave_type           next_carry
);

   rec_type  rec_ff, rec_in;
   wave_type carry_ff, carry_in;
   logic     shift_left;
   logic     match;
   logic     first_hit;
   logic     take;

   // slot at or past the insert point (head slot only yields to a strictly larger key)
   assign flag = head ? (!rec_ff.valid || (rec_ff.key > ctrl.key))
                      : (!rec_ff.valid || (rec_ff.key >= ctrl.key));

   assign shift_left = rec_ff.valid && (rec_ff.key >= ctrl.key);

   always_comb begin
      rec_in = rec_ff;
      if (ctrl.ins) begin
         if (flag && !left_flag) begin
            rec_in.valid   = 1'b1;
            rec_in.key     = ctrl.key;
            rec_in.likes   = ctrl.likes;
            rec_in.payload = ctrl.payload;
         end else if (flag) begin
            rec_in = left_rec;
         end
      end else if (ctrl.del && shift_left) begin
         rec_in = right_rec;
      end
   end

   always_comb begin
      match     = rec_ff.valid && (rec_ff.key == ctrl.key);
      first_hit = match && !prev_carry.found;
      // a record about to be deleted takes no part in the max
      take      = rec_ff.valid && !(first_hit && ctrl.kind_del)
                  && (!prev_carry.best_valid || (rec_ff.likes > prev_carry.best_likes));
      carry_in       = prev_carry;
      carry_in.found = prev_carry.found || match;
      if (first_hit) begin
         carry_in.hit_likes   = rec_ff.likes;
         carry_in.hit_payload = rec_ff.payload;
      end
      if (take) begin
         carry_in.best_valid   = 1'b1;
         carry_in.best_key     = rec_ff.key;
         carry_in.best_likes   = rec_ff.likes;
         carry_in.best_payload = rec_ff.payload;
      end
   end

   // only the valid bit is reset, the record fields follow it
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.valid <= 1'b0;
      end else begin
         rec_ff.valid <= rec_in.valid;
      end
      rec_ff.key     <= rec_in.key;
      rec_ff.likes   <= rec_in.likes;
      rec_ff.payload <= rec_in.payload;
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
   end

   assign rec        = rec_ff;
   assign next_carry = carry_ff;

endmodule

`default_nettype wire

// ----- verif/sorted_record_table_test.sv -----
// self-checking testbench for the sorted record table: directed and random requests against a mirror
module sorted_record_table_test;
   timeunit 1ns;
   timeprecision 1ps;
   import srt_pkg::*;

   localparam int DEPTH        = CAPACITY_DEFAULT;
   localparam int HOLD_CYCLES  = 400;          // long receiver hold-off, in cycles
   localparam int QUIET_LIMIT  = 4000;         // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = DEPTH + 16;   // one full scan wave plus margin
   localparam int REPORT_LIMIT = 10;

   // mirror of the table contents; predicts one response per accepted request
   class record_table_mirror;
      logic signed [KEY_W-1:0] rec_key     [DEPTH];
      logic [LIKES_W-1:0]      rec_likes   [DEPTH];
      logic [PAYLOAD_W-1:0]    rec_payload [DEPTH];
      int                      held;
      int                      failures;
      rsp_type                 awaited [$];

      function new();
         held     = 0;
         failures = 0;
      endfunction

      function string describe(rsp_type r);
         return $sformatf({"status=%0d hit_likes=%0d hit_payload=%h count=%0d ",
                           "top_valid=%b top_key=%0d top_likes=%0d top_payload=%h"},
                          r.status, r.hit_likes, r.hit_payload, r.entry_count,
                          r.top_valid, $signed(r.top_key), r.top_likes, r.top_payload);
      endfunction

      function logic signed [KEY_W-1:0] held_key();
         if (held == 0) begin
            return $urandom();
         end
         return rec_key[$urandom_range(held - 1)];
      endfunction

      function void take_request(req_type r);
         rsp_type res;
         int      pos;
         int      best;
         res = '0;
         case (r.kind)
            KIND_INSERT: begin
               if (held >= DEPTH) begin
                  res.status = STATUS_FULL;
               end else begin
                  // a key equal to the first key lands right after the first record
                  if (held == 0 || $signed(rec_key[0]) > $signed(r.key)) begin
                     pos = 0;
                  end else begin
                     pos = 1;
                     while (pos < held && $signed(rec_key[pos]) < $signed(r.key)) pos++;
                  end
                  for (int i = held; i > pos; i--) begin
                     rec_key[i]     = rec_key[i-1];
                     rec_likes[i]   = rec_likes[i-1];
                     rec_payload[i] = rec_payload[i-1];
                  end
                  rec_key[pos]     = r.key;
                  rec_likes[pos]   = r.new_likes;
                  rec_payload[pos] = r.new_payload;
                  held++;
               end
            end
            KIND_DELETE, KIND_LOOKUP: begin
               if (held == 0) begin
                  res.status = STATUS_EMPTY;
               end else begin
                  pos = 0;
                  while (pos < held && rec_key[pos] != r.key) pos++;
                  if (pos == held) begin
                     res.status = STATUS_NOT_FOUND;
                  end else begin
                     res.hit_likes   = rec_likes[pos];
                     res.hit_payload = rec_payload[pos];
                     if (r.kind == KIND_DELETE) begin
                        for (int i = pos; i + 1 < held; i++) begin
                           rec_key[i]     = rec_key[i+1];
                           rec_likes[i]   = rec_likes[i+1];
                           rec_payload[i] = rec_payload[i+1];
                        end
                        held--;
                     end
                  end
               end
            end
            default: ;
         endcase
         res.entry_count = held[COUNT_W-1:0];
         if (held > 0) begin
            // strict compare keeps the earliest record on a tie
            best = 0;
            for (int i = 1; i < held; i++) begin
               if (rec_likes[i] > rec_likes[best]) best = i;
            end
            res.top_valid   = 1'b1;
            res.top_key     = rec_key[best];
            res.top_likes   = rec_likes[best];
            res.top_payload = rec_payload[best];
         end
         awaited.push_back(res);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("unexpected response: %s", describe(got));
            end
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status || got.hit_likes !== want.hit_likes ||
             got.hit_payload !== want.hit_payload || got.entry_count !== want.entry_count ||
             got.top_valid !== want.top_valid || got.top_key !== want.top_key ||
             got.top_likes !== want.top_likes || got.top_payload !== want.top_payload) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("response mismatch\n  expected %s\n  actual   %s",
                        describe(want), describe(got));
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // knobs shared between the main sequence and the receiver process
   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int hold_off_cycles = 0;
   bit filling         = 1'b1;   // random part leans toward inserts while set

   record_table_mirror mirror = new();

   sorted_record_table #(.CAPACITY(DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // receiver: random stalls, or a long hold-off counted down here
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // every accepted response is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) mirror.check_response(rsp_data);
   end

   // watchdog: ends the run when no handshake happens for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("FAIL sorted_record_table");
      $finish;
   end

   function automatic req_type request_of(kind_type kind, logic signed [KEY_W-1:0] key,
                                          logic [LIKES_W-1:0] likes,
                                          logic [PAYLOAD_W-1:0] payload);
      req_type r;
      r.kind        = kind;
      r.key         = key;
      r.new_likes   = likes;
      r.new_payload = payload;
      return r;
   endfunction

   // extremes plus a narrow band around zero, so duplicates are common
   function automatic logic signed [KEY_W-1:0] pool_key();
      case ($urandom_range(7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return 32'sh0000_0000;
         3:       return -32'sd1;
         default: return int'($urandom_range(20)) - 10;
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      // swing between filling and draining at the two extremes, lingering a little
      // so that inserts into a full table and deletes on an empty one happen
      if (filling && mirror.held >= DEPTH && $urandom_range(3) == 0) filling = 1'b0;
      else if (!filling && mirror.held == 0 && $urandom_range(3) == 0) filling = 1'b1;
      pick = $urandom_range(99);
      if (pick < 4)       r.kind = KIND_NONE;
      else if (pick < 24) r.kind = KIND_LOOKUP;
      else if (pick < 84) r.kind = filling ? KIND_INSERT : KIND_DELETE;
      else                r.kind = filling ? KIND_DELETE : KIND_INSERT;
      if (r.kind == KIND_INSERT) begin
         r.key = $urandom_range(1) ? pool_key() : $urandom();
      end else begin
         pick = $urandom_range(9);
         if (pick < 5)      r.key = mirror.held_key();
         else if (pick < 8) r.key = pool_key();
         else               r.key = $urandom();
      end
      // small like counts make ties for the most-liked record
      case ($urandom_range(7))
         0:       r.new_likes = LIKES_W'($urandom_range(3));
         1:       r.new_likes = '1;
         default: r.new_likes = LIKES_W'($urandom());
      endcase
      r.new_payload = PAYLOAD_W'($urandom());
      return r;
   endfunction

   // offer one request after a random gap; returns at the edge that took it
   task automatic send_request(input req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      mirror.take_request(r);
   endtask

   task automatic run_directed();
      send_idle_pct = 0;
      stall_pct     = 0;
      // lookup, delete and an unused kind on an empty table
      send_request(request_of(KIND_LOOKUP, 5, 0, 0));
      send_request(request_of(KIND_DELETE, 32'sh8000_0000, 0, 0));
      send_request(request_of(KIND_NONE, 32'sh1234_5678, 31'h7fff_ffff, 16'hffff));
      // three records with the same key: the later two go right after the first
      send_request(request_of(KIND_INSERT, 0, 10, 16'h0001));
      send_request(request_of(KIND_INSERT, 0, 10, 16'h0002));
      send_request(request_of(KIND_INSERT, 0, 3, 16'h0003));
      // key and likes extremes, a tie on the top like count
      send_request(request_of(KIND_INSERT, 32'sh8000_0000, 31'h7fff_ffff, 16'hffff));
      send_request(request_of(KIND_INSERT, 32'sh7fff_ffff, 0, 16'h0000));
      send_request(request_of(KIND_INSERT, -1, 31'h7fff_ffff, 16'h1234));
      // hit, delete and the record behind it
      send_request(request_of(KIND_LOOKUP, 0, 0, 0));
      send_request(request_of(KIND_DELETE, 0, 0, 0));
      send_request(request_of(KIND_LOOKUP, 0, 0, 0));
      // missing key
      send_request(request_of(KIND_LOOKUP, 7, 0, 0));
      send_request(request_of(KIND_DELETE, 7, 0, 0));
      // removing the most-liked record moves the top to the tie loser
      send_request(request_of(KIND_DELETE, 32'sh8000_0000, 0, 0));
      send_request(request_of(KIND_INSERT, 32'sh7fff_ffff, 5, 16'haaaa));
      send_request(request_of(KIND_INSERT, 32'sh5555_5555, 31'h2aaa_aaaa, 16'h5555));
      send_request(request_of(KIND_INSERT, 32'shaaaa_aaaa, 31'h5555_5555, 16'haaaa));
      send_request(request_of(KIND_LOOKUP, 32'sh7fff_ffff, 0, 0));
      send_request(request_of(KIND_NONE, 32'shdead_beef, 31'h0, 16'h0));
      send_request(request_of(KIND_DELETE, 32'sh7fff_ffff, 0, 0));
      send_request(request_of(KIND_DELETE, 32'sh7fff_ffff, 0, 0));
      send_request(request_of(KIND_LOOKUP, 32'sh7fff_ffff, 0, 0));
   endtask

   // one idling phase; hold_at picks the request count where the long hold-off starts
   task automatic run_random(input int count, input int idle, input int stall,
                             input int hold_at);
      req_type r;
      int      sent;
      send_idle_pct = idle;
      stall_pct     = stall;
      sent          = 0;
      while (sent < count) begin
         if (sent == hold_at && hold_off_cycles == 0) hold_off_cycles = HOLD_CYCLES;
         r = random_request();
         send_request(r);
         // ignored requests do not count toward the phase
         if (r.kind != KIND_NONE) sent++;
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      // back to back, with the long hold-off in the middle to back the block up
      run_random(470, 0, 0, 235);
      run_random(470, 72, 0, -1);
      run_random(470, 0, 72, -1);
      run_random(470, 27, 27, -1);

      @(negedge clock);
      req_valid <= 1'b0;
      // the watchdog covers a response that never comes
      while (mirror.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mirror.failures == 0 && mirror.awaited.size() == 0) begin
         $display("PASS sorted_record_table");
      end else begin
         $display("FAIL sorted_record_table");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/srt_pkg.sv
sv/srt_cell.sv
sv/sorted_record_table.sv
verif/sorted_record_table_test.sv
